// ----- hw/rtl/fdcd_pkg.sv -----
// shared types and constants of the frame delta command decoder
package fdcd_pkg;

   localparam int unsigned BLOCK_WORDS   = 255;
   localparam int unsigned BANK_ROWS     = 64;
   localparam int unsigned ROW_W         = 6;
   localparam int unsigned FRAME_SIZE_W  = 25;
   localparam logic [24:0] FRAME_SIZE_RST = 25'd614400;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [0:0] REG_FRAME_SIZE = 1'b0;

   typedef struct packed {
      logic capture;
      logic step;
      logic rd;
      logic emit;
   } ctl_cmd_type;

   typedef struct packed {
      logic step_emits;
      logic step_replay;
      logic rep_last;
      logic out_free;
   } ctl_status_type;

endpackage

// ----- hw/rtl/fdcd_ctrl.sv -----
// sequencer: byte capture, parse step and block replay
module fdcd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  fdcd_pkg::ctl_status_type st,
   output fdcd_pkg::ctl_cmd_type    cmd
);
   import fdcd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!st.step_emits || st.out_free) begin
               cmd.step = 1'b1;
               state_in = st.step_replay ? S_READ : S_IDLE;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = st.rep_last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/fdcd_datapath.sv -----
// parse registers, block store banks and result register
module fdcd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  fdcd_pkg::ctl_cmd_type   cmd,
   output fdcd_pkg::ctl_status_type st,
   input  logic [7:0]              in_byte,
   input  logic                    in_eos,
   input  logic [24:0]             frame_size,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [1:0]              out_kind,
   output logic [22:0]             out_addr,
   output logic [23:0]             out_count,
   output logic [15:0]             out_w0,
   output logic [15:0]             out_w1,
   output logic [15:0]             out_w2,
   output logic [15:0]             out_w3,
   output logic                    out_err,
   output logic                    out_last
);
   import fdcd_pkg::*;

   localparam logic [3:0] PH_WAIT    = 4'd0;
   localparam logic [3:0] PH_OFFSET  = 4'd1;
   localparam logic [3:0] PH_COUNT   = 4'd2;
   localparam logic [3:0] PH_LIT     = 4'd3;
   localparam logic [3:0] PH_FILLVAL = 4'd4;
   localparam logic [3:0] PH_BLEN    = 4'd5;
   localparam logic [3:0] PH_OCOUNT  = 4'd6;
   localparam logic [3:0] PH_BDATA   = 4'd7;
   localparam logic [3:0] PH_BOFFSET = 4'd8;
   localparam logic [3:0] PH_DROP    = 4'd9;

   logic [7:0]  byte_ff;
   logic        eos_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [1:0]  bc_ff, bc_in;
   logic [1:0]  ckind_ff, ckind_in;
   logic [31:0] aw_ff, aw_in;
   logic [31:0] off_ff, off_in;
   logic [31:0] wr_ff, wr_in;
   logic [15:0] fill_ff, fill_in;
   logic [7:0]  blen_ff, blen_in;
   logic [31:0] orem_ff, orem_in;
   logic [7:0]  low_ff, low_in;
   logic        err_ff, err_in;

   logic [31:0] gathered;
   logic        gdone;
   logic [15:0] word;
   logic [31:0] chk_off, chk_cnt;
   logic [32:0] chk_sum;
   logic        inb;
   logic [7:0]  widx;
   logic        mem_we;
   logic        single;
   logic [1:0]  s_kind;
   logic [22:0] s_addr;
   logic [23:0] s_cnt;
   logic [15:0] s_w0;
   logic        s_err;
   logic        replay;

   logic [15:0] bank0 [BANK_ROWS];
   logic [15:0] bank1 [BANK_ROWS];
   logic [15:0] bank2 [BANK_ROWS];
   logic [15:0] bank3 [BANK_ROWS];
   logic [15:0] rd0_ff, rd1_ff, rd2_ff, rd3_ff;
   logic [7:0]  pos_ff;
   logic [22:0] roff_ff;
   logic [7:0]  left;
   logic [2:0]  rc;

   logic        ov_ff;
   logic [1:0]  ok_ff;
   logic [22:0] oa_ff;
   logic [23:0] oc_ff;
   logic [15:0] o0_ff, o1_ff, o2_ff, o3_ff;
   logic        oe_ff, ol_ff;

   assign gathered = aw_ff | (32'(byte_ff) << {bc_ff, 3'b000});
   assign gdone    = (bc_ff == 2'd3);
   assign word     = {byte_ff, low_ff};
   assign chk_off  = (phase_ff == PH_BOFFSET) ? gathered : off_ff;
   assign chk_cnt  = (phase_ff == PH_BOFFSET) ? {24'd0, blen_ff} : gathered;
   assign chk_sum  = {1'b0, chk_off} + {1'b0, chk_cnt};
   assign inb      = ({chk_sum, 1'b0} <= {9'd0, frame_size});
   assign widx     = blen_ff - wr_ff[7:0];

   always_comb begin
      phase_in = phase_ff;  bc_in = bc_ff;     ckind_in = ckind_ff;
      aw_in    = aw_ff;     off_in = off_ff;   wr_in = wr_ff;
      fill_in  = fill_ff;   blen_in = blen_ff; orem_in = orem_ff;
      low_in   = low_ff;    err_in = err_ff;
      single = 1'b0; s_kind = KIND_WRITE; s_addr = '0; s_cnt = '0;
      s_w0 = '0; s_err = 1'b0; replay = 1'b0; mem_we = 1'b0;
      if (eos_ff) begin
         single = 1'b1; s_kind = KIND_END; s_err = err_ff;
         phase_in = PH_WAIT; bc_in = '0; ckind_in = '0; aw_in = '0; off_in = '0;
         wr_in = '0; fill_in = '0; blen_in = '0; orem_in = '0; low_in = '0;
         err_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_WAIT: begin
               if (byte_ff == 8'h20) begin
                  ckind_in = KIND_WRITE; phase_in = PH_OFFSET; bc_in = '0; aw_in = '0;
               end else if (byte_ff == 8'h40) begin
                  ckind_in = KIND_FILL; bc_in = '0; phase_in = PH_FILLVAL;
               end else if (byte_ff == 8'h80) begin
                  ckind_in = KIND_END; phase_in = PH_BLEN;
               end
            end
            PH_FILLVAL: begin
               if (bc_ff == 2'd0) begin
                  low_in = byte_ff; bc_in = 2'd1;
               end else begin
                  fill_in = word; phase_in = PH_OFFSET; bc_in = '0; aw_in = '0;
               end
            end
            PH_OFFSET: begin
               aw_in = gathered;
               bc_in = gdone ? 2'd0 : bc_ff + 2'd1;
               if (gdone) begin
                  off_in = gathered; phase_in = PH_COUNT; aw_in = '0;
               end
            end
            PH_COUNT: begin
               aw_in = gathered;
               bc_in = gdone ? 2'd0 : bc_ff + 2'd1;
               if (gdone) begin
                  if (!inb) begin
                     err_in = 1'b1; phase_in = PH_DROP;
                  end else if (ckind_ff == KIND_FILL) begin
                     if (gathered != 32'd0) begin
                        single = 1'b1; s_kind = KIND_FILL; s_addr = off_ff[22:0];
                        s_cnt = gathered[23:0]; s_w0 = fill_ff;
                     end
                     phase_in = PH_WAIT;
                  end else if (gathered == 32'd0) begin
                     phase_in = PH_WAIT;
                  end else begin
                     wr_in = gathered; phase_in = PH_LIT;
                  end
               end
            end
            PH_LIT: begin
               if (bc_ff == 2'd0) begin
                  low_in = byte_ff; bc_in = 2'd1;
               end else begin
                  bc_in = '0; single = 1'b1; s_kind = KIND_WRITE;
                  s_addr = off_ff[22:0]; s_cnt = 24'd1; s_w0 = word;
                  off_in = off_ff + 32'd1; wr_in = wr_ff - 32'd1;
                  if (wr_ff == 32'd1) phase_in = PH_WAIT;
               end
            end
            PH_BLEN: begin
               blen_in = byte_ff; phase_in = PH_OCOUNT; bc_in = '0; aw_in = '0;
            end
            PH_OCOUNT: begin
               aw_in = gathered;
               bc_in = gdone ? 2'd0 : bc_ff + 2'd1;
               if (gdone) begin
                  orem_in = gathered; wr_in = {24'd0, blen_ff};
                  if (blen_ff != 8'd0) begin
                     phase_in = PH_BDATA;
                  end else if (gathered != 32'd0) begin
                     phase_in = PH_BOFFSET; aw_in = '0;
                  end else begin
                     phase_in = PH_WAIT;
                  end
               end
            end
            PH_BDATA: begin
               if (bc_ff == 2'd0) begin
                  low_in = byte_ff; bc_in = 2'd1;
               end else begin
                  bc_in = '0; mem_we = 1'b1; wr_in = wr_ff - 32'd1;
                  if (wr_ff == 32'd1) begin
                     if (orem_ff != 32'd0) begin
                        phase_in = PH_BOFFSET; aw_in = '0;
                     end else begin
                        phase_in = PH_WAIT;
                     end
                  end
               end
            end
            PH_BOFFSET: begin
               aw_in = gathered;
               bc_in = gdone ? 2'd0 : bc_ff + 2'd1;
               if (gdone) begin
                  if (!inb) begin
                     err_in = 1'b1; phase_in = PH_DROP;
                  end else begin
                     replay  = (blen_ff != 8'd0);
                     orem_in = orem_ff - 32'd1;
                     aw_in   = '0;
                     if (orem_ff == 32'd1) phase_in = PH_WAIT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // replay slice
   assign left = blen_ff - pos_ff;
   assign rc   = (left < 8'd4) ? left[2:0] : 3'd4;

   assign st.step_emits  = single;
   assign st.step_replay = replay;
   assign st.rep_last    = (left <= 8'd4);
   assign st.out_free    = !ov_ff || out_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         byte_ff <= in_byte;
         eos_ff  <= in_eos;
      end
      if (cmd.step && mem_we) begin
         unique case (widx[1:0])
            2'd0: bank0[widx[7:2]] <= word;
            2'd1: bank1[widx[7:2]] <= word;
            2'd2: bank2[widx[7:2]] <= word;
            2'd3: bank3[widx[7:2]] <= word;
            default: bank0[widx[7:2]] <= word;
         endcase
      end
      if (cmd.rd) begin
         rd0_ff <= bank0[pos_ff[7:2]];
         rd1_ff <= bank1[pos_ff[7:2]];
         rd2_ff <= bank2[pos_ff[7:2]];
         rd3_ff <= bank3[pos_ff[7:2]];
      end
      if (cmd.step && replay) begin
         pos_ff  <= '0;
         roff_ff <= gathered[22:0];
      end else if (cmd.emit) begin
         pos_ff <= pos_ff + 8'd4;
      end
      if (cmd.step && single) begin
         ok_ff <= s_kind; oa_ff <= s_addr; oc_ff <= s_cnt; o0_ff <= s_w0;
         o1_ff <= '0; o2_ff <= '0; o3_ff <= '0; oe_ff <= s_err; ol_ff <= 1'b1;
      end else if (cmd.emit) begin
         ok_ff <= KIND_WRITE;
         oa_ff <= roff_ff + 23'(pos_ff);
         oc_ff <= 24'(rc);
         o0_ff <= rd0_ff;
         o1_ff <= (rc > 3'd1) ? rd1_ff : 16'd0;
         o2_ff <= (rc > 3'd2) ? rd2_ff : 16'd0;
         o3_ff <= (rc > 3'd3) ? rd3_ff : 16'd0;
         oe_ff <= 1'b0;
         ol_ff <= (left <= 8'd4);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT; bc_ff <= '0; ckind_ff <= '0; aw_ff <= '0; off_ff <= '0;
         wr_ff <= '0; fill_ff <= '0; blen_ff <= '0; orem_ff <= '0; low_ff <= '0;
         err_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            phase_ff <= phase_in; bc_ff <= bc_in; ckind_ff <= ckind_in; aw_ff <= aw_in;
            off_ff <= off_in; wr_ff <= wr_in; fill_ff <= fill_in; blen_ff <= blen_in;
            orem_ff <= orem_in; low_ff <= low_in; err_ff <= err_in;
         end
         if ((cmd.step && single) || cmd.emit) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_kind  = ok_ff;
   assign out_addr  = oa_ff;
   assign out_count = oc_ff;
   assign out_w0    = o0_ff;
   assign out_w1    = o1_ff;
   assign out_w2    = o2_ff;
   assign out_w3    = o3_ff;
   assign out_err   = oe_ff;
   assign out_last  = ol_ff;

endmodule

// ----- hw/rtl/frame_delta_command_decoder.sv -----
// top level of the frame delta command decoder
//
//  channel  dir  contents
//  req_*    in   one stream byte per transfer, tuser marks end of stream
//  rsp_*    out  frame buffer write, fill run or end status per transfer
//  csr_*    in   register access, frame size at byte address 0
//
// a byte is captured, then taken by one parse step
// a block offset replays the stored block as ceil(length/4) writes, each a read
// through the single read port of each of the four store banks, then an emit
// reset is synchronous and active high; the block store is not cleared
// a result waiting on rsp_tready holds the next parse step that has a result
module frame_delta_command_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,    // data_byte
   input  logic         req_tuser,    // end_of_stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // word_address[22:0], word_count[46:23], word_zero[62:47], word_one[78:63],
   // word_two[94:79], word_three[110:95], zero pad
   output logic [111:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,    // kind[1:0], error_flag[2]
   output logic         rsp_tlast,    // last_of_run
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import fdcd_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type st;
   logic [24:0]    frame_size_ff;
   logic           reg_hit;
   logic [1:0]     o_kind;
   logic [22:0]    o_addr;
   logic [23:0]    o_cnt;
   logic [15:0]    o_w0, o_w1, o_w2, o_w3;
   logic           o_err;

   // register port, only the frame size exists
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[2] == REG_FRAME_SIZE) && (csr_paddr[1:0] == 2'd0);
   assign csr_prdata = reg_hit ? {7'd0, frame_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_hit) begin
         frame_size_ff <= csr_pwdata[FRAME_SIZE_W-1:0];
      end
   end

   fdcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   fdcd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .in_byte    (req_tdata),
      .in_eos     (req_tuser),
      .frame_size (frame_size_ff),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_kind   (o_kind),
      .out_addr   (o_addr),
      .out_count  (o_cnt),
      .out_w0     (o_w0),
      .out_w1     (o_w1),
      .out_w2     (o_w2),
      .out_w3     (o_w3),
      .out_err    (o_err),
      .out_last   (rsp_tlast)
   );

   // result transfer packing
   assign rsp_tdata = {1'b0, o_w3, o_w2, o_w1, o_w0, o_cnt, o_addr};
   assign rsp_tuser = {o_err, o_kind};

endmodule
